### hw/rtl/sat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_pkg: shared types and constants
// Widths, configuration register codes and pipeline payload records for the
// segment attractor falloff weight block.
// ----------------------------------------------------------------------------
package sat_pkg;

    localparam int CoordW    = 32;  // coordinate, gain and weight width
    localparam int DistW     = 31;  // radius and distance width
    localparam int MagW      = 33;  // magnitude of a coordinate difference
    localparam int TBits     = 30;  // projection fraction bits
    localparam int LenW      = 68;  // sum of three MagW x MagW products
    localparam int Dist2W    = 64;  // squared distance
    localparam int RootW     = 64;  // square root working width
    localparam int SqrtSteps = 32;  // one result bit per sqrt cell
    localparam int WQW       = 32;  // weight quotient magnitude width
    localparam int CfgIdxW   = 3;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_ATT_X      = 3'd0,
        CFG_ATT_Y      = 3'd1,
        CFG_ATT_Z      = 3'd2,
        CFG_ATT_RADIUS = 3'd3,
        CFG_ATT_GAIN   = 3'd4
    } t_cfg_idx;

    // geometry carried alongside the projection divider
    typedef struct packed {
        logic [2:0][MagW-1:0] dmag;
        logic [2:0]           dneg;
        logic [2:0][MagW-1:0] vmag;
        logic [2:0]           vneg;
        logic                 full;
    } t_geo;

    // context carried alongside the weight divider
    typedef struct packed {
        logic [WQW-1:0]   num_lo;
        logic             neg;
        logic [DistW-1:0] distance;
        logic             oor;
    } t_wgt;

endpackage

### hw/rtl/segment_attractor_falloff_weight.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_attractor_falloff_weight: closest point and linear falloff weight
// Throughput: one beat per cycle; the whole pipeline holds while a result
// waits on output stall. Depth is set by the 30-cell projection divider,
// the 32-cell square root chain and the 32-cell weight divider.
// Reset: synchronous, active low; clears valid bits, attractor registers and
// the output register to 0; datapath registers are left as they are.
// ----------------------------------------------------------------------------
module segment_attractor_falloff_weight
    import sat_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CfgIdxW-1:0]    i_cfg_idx,
    input  logic [CoordW-1:0]     i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic signed [CoordW-1:0] i_start_x,
    input  logic signed [CoordW-1:0] i_start_y,
    input  logic signed [CoordW-1:0] i_start_z,
    input  logic signed [CoordW-1:0] i_end_x,
    input  logic signed [CoordW-1:0] i_end_y,
    input  logic signed [CoordW-1:0] i_end_z,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic signed [CoordW-1:0] o_falloff_weight,
    output logic [DistW-1:0]      o_closest_distance,
    output logic                  o_out_of_range
);

    // configuration
    logic signed [CoordW-1:0] r_att_x, r_att_y, r_att_z, r_att_gain;
    logic [DistW-1:0]         r_att_rad;
    logic [2*DistW-1:0]       r_rad2;

    logic w_en;

    // stage 1..4
    logic [2:0][CoordW-1:0] w_s, w_e, w_a;
    logic [2:0][MagW-1:0]   w_d, w_v, w_dmag, w_vmag;
    logic [2:0]             w_dneg, w_vneg;

    logic                   r1_vld;
    logic [2:0][MagW-1:0]   r1_dmag, r1_vmag;
    logic [2:0]             r1_dneg, r1_vneg;

    logic                   r2_vld;
    logic [2:0][2*MagW-1:0] r2_dd, r2_dv;
    logic [2:0][MagW-1:0]   r2_dmag, r2_vmag;
    logic [2:0]             r2_dneg, r2_vneg;

    logic                   r3_vld;
    logic [LenW-1:0]        r3_len2, r3_pos, r3_neg;
    logic [2:0][MagW-1:0]   r3_dmag, r3_vmag;
    logic [2:0]             r3_dneg, r3_vneg;
    logic [LenW-1:0]        w_len2, w_pos, w_neg;

    logic                   w_gt, w_full, w_lz;
    logic [LenW-1:0]        w_rem0;
    logic                   r4_vld;
    logic [LenW-1:0]        r4_rem, r4_den;
    t_geo                   r4_geo;

    // projection divider chain
    logic                   w_pvld [0:TBits];
    logic [LenW-1:0]        w_prem [0:TBits];
    logic [LenW-1:0]        w_pden [0:TBits];
    logic [TBits-1:0]       w_pq   [0:TBits];
    t_geo                   w_pgeo [0:TBits];

    // stage 5..8
    t_geo                   w_geo;
    logic [TBits:0]         w_t;
    logic                   r5_vld;
    logic [2:0][63:0]       r5_prod;
    logic [2:0][MagW-1:0]   r5_vmag;
    logic [2:0]             r5_dneg, r5_vneg;

    logic [2:0][MagW-1:0]   w_off;
    logic [2:0][MagW+1:0]   w_ex, w_ev, w_eo, w_m;
    logic [2:0]             w_big;
    logic                   r6_vld, r6_sat;
    logic [2:0][DistW-1:0]  r6_m;

    logic                   r7_vld, r7_sat;
    logic [2:0][2*DistW-1:0] r7_sq;

    logic [Dist2W-1:0]      w_sum, w_dist2;
    logic                   r8_vld, r8_oor;
    logic [Dist2W-1:0]      r8_dist2;

    // square root chain
    logic                   w_svld  [0:SqrtSteps];
    logic [RootW-1:0]       w_srem  [0:SqrtSteps];
    logic [RootW-1:0]       w_sroot [0:SqrtSteps];
    logic                   w_soor  [0:SqrtSteps];

    // stage 9..10
    logic [DistW-1:0]       w_dist;
    logic [CoordW-1:0]      w_diff;
    logic signed [63:0]     w_wprod;
    logic                   r9_vld, r9_oor;
    logic signed [63:0]     r9_prod;
    logic [DistW-1:0]       r9_dist;

    logic [63:0]            w_pmag;
    logic                   r10_vld;
    logic [DistW-1:0]       r10_rem;
    t_wgt                   r10_pay;

    // weight divider chain
    logic                   w_wvld [0:WQW];
    logic [DistW-1:0]       w_wrem [0:WQW];
    logic [DistW-1:0]       w_wden [0:WQW];
    logic [WQW-1:0]         w_wq   [0:WQW];
    t_wgt                   w_wpay [0:WQW];

    // output
    t_wgt                   w_last;
    logic [WQW-1:0]         w_q;
    logic                   r_out_vld;
    logic signed [CoordW-1:0] r_out_w;
    logic [DistW-1:0]       r_out_d;
    logic                   r_out_oor;

    // hold every stage while a result waits
    assign w_en       = !(r_out_vld && i_out_stall);
    assign o_in_stall = r_out_vld && i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_att_x    <= '0;
            r_att_y    <= '0;
            r_att_z    <= '0;
            r_att_rad  <= '0;
            r_att_gain <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ATT_X:      r_att_x    <= i_cfg_data;
                CFG_ATT_Y:      r_att_y    <= i_cfg_data;
                CFG_ATT_Z:      r_att_z    <= i_cfg_data;
                CFG_ATT_RADIUS: r_att_rad  <= i_cfg_data[DistW-1:0];
                CFG_ATT_GAIN:   r_att_gain <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad2 <= {{DistW{1'b0}}, r_att_rad} * {{DistW{1'b0}}, r_att_rad};
    end

    // stage 1: differences and magnitudes
    always_comb begin
        w_s = {i_start_z, i_start_y, i_start_x};
        w_e = {i_end_z, i_end_y, i_end_x};
        w_a = {r_att_z, r_att_y, r_att_x};
        for (int i = 0; i < 3; i++) begin
            w_d[i]    = {w_e[i][CoordW-1], w_e[i]} - {w_s[i][CoordW-1], w_s[i]};
            w_v[i]    = {w_a[i][CoordW-1], w_a[i]} - {w_s[i][CoordW-1], w_s[i]};
            w_dneg[i] = w_d[i][MagW-1];
            w_vneg[i] = w_v[i][MagW-1];
            w_dmag[i] = w_dneg[i] ? -w_d[i] : w_d[i];
            w_vmag[i] = w_vneg[i] ? -w_v[i] : w_v[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_in_valid;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
        end
    end

    // stage 3 sums
    always_comb begin
        w_len2 = '0;
        w_pos  = '0;
        w_neg  = '0;
        for (int i = 0; i < 3; i++) begin
            w_len2 = w_len2 + {2'b00, r2_dd[i]};
            if (r2_dneg[i] == r2_vneg[i]) begin
                w_pos = w_pos + {2'b00, r2_dv[i]};
            end else begin
                w_neg = w_neg + {2'b00, r2_dv[i]};
            end
        end
    end

    // stage 4: set up the projection quotient
    assign w_lz   = (r3_len2 == '0);
    assign w_gt   = r3_pos > r3_neg;
    assign w_rem0 = r3_pos - r3_neg;
    assign w_full = !w_lz && w_gt && (w_rem0 >= r3_len2);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_dmag <= w_dmag;
            r1_vmag <= w_vmag;
            r1_dneg <= w_dneg;
            r1_vneg <= w_vneg;
            for (int i = 0; i < 3; i++) begin
                r2_dd[i] <= {{MagW{1'b0}}, r1_dmag[i]} * {{MagW{1'b0}}, r1_dmag[i]};
                r2_dv[i] <= {{MagW{1'b0}}, r1_dmag[i]} * {{MagW{1'b0}}, r1_vmag[i]};
            end
            r2_dmag <= r1_dmag;
            r2_vmag <= r1_vmag;
            r2_dneg <= r1_dneg;
            r2_vneg <= r1_vneg;
            r3_len2 <= w_len2;
            r3_pos  <= w_pos;
            r3_neg  <= w_neg;
            r3_dmag <= r2_dmag;
            r3_vmag <= r2_vmag;
            r3_dneg <= r2_dneg;
            r3_vneg <= r2_vneg;
            // zero-length segment: dummy divisor keeps the quotient at zero
            r4_rem  <= (!w_lz && w_gt && !w_full) ? w_rem0 : '0;
            r4_den  <= w_lz ? '1 : r3_len2;
            r4_geo.dmag <= r3_dmag;
            r4_geo.dneg <= r3_dneg;
            r4_geo.vmag <= r3_vmag;
            r4_geo.vneg <= r3_vneg;
            r4_geo.full <= w_full;
        end
    end

    assign w_pvld[0] = r4_vld;
    assign w_prem[0] = r4_rem;
    assign w_pden[0] = r4_den;
    assign w_pq[0]   = '0;
    assign w_pgeo[0] = r4_geo;

    for (genvar k = 0; k < TBits; k++) begin : g_pdiv
        sat_div_cell #(
            .REM_W (LenW),
            .Q_W   (TBits),
            .PAY_W ($bits(t_geo))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_pvld[k]),
            .i_rem   (w_prem[k]),
            .i_den   (w_pden[k]),
            .i_bit   (1'b0),
            .i_q     (w_pq[k]),
            .i_pay   (w_pgeo[k]),
            .o_vld   (w_pvld[k+1]),
            .o_rem   (w_prem[k+1]),
            .o_den   (w_pden[k+1]),
            .o_q     (w_pq[k+1]),
            .o_pay   (w_pgeo[k+1])
        );
    end

    // stage 5: offsets along the segment
    assign w_geo = w_pgeo[TBits];
    assign w_t   = w_geo.full ? {1'b1, {TBits{1'b0}}} : {1'b0, w_pq[TBits]};

    // stage 6: error vector and saturation
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_off[i] = r5_prod[i][TBits+MagW-1:TBits];
            w_eo[i]  = r5_dneg[i] ? -{2'b00, w_off[i]} : {2'b00, w_off[i]};
            w_ev[i]  = r5_vneg[i] ? -{2'b00, r5_vmag[i]} : {2'b00, r5_vmag[i]};
            w_ex[i]  = w_eo[i] - w_ev[i];
            w_m[i]   = w_ex[i][MagW+1] ? -w_ex[i] : w_ex[i];
            w_big[i] = (w_m[i][MagW+1:DistW] != '0);
        end
    end

    // stage 8: squared distance and range test
    assign w_sum   = {2'b00, r7_sq[0]} + {2'b00, r7_sq[1]} + {2'b00, r7_sq[2]};
    assign w_dist2 = r7_sat ? '1 : w_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_vld <= 1'b0;
            r6_vld <= 1'b0;
            r7_vld <= 1'b0;
            r8_vld <= 1'b0;
        end else if (w_en) begin
            r5_vld <= w_pvld[TBits];
            r6_vld <= r5_vld;
            r7_vld <= r6_vld;
            r8_vld <= r7_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r5_prod[i] <= {{TBits+1{1'b0}}, w_geo.dmag[i]} * {{MagW{1'b0}}, w_t};
                r6_m[i]    <= w_m[i][DistW-1:0];
                r7_sq[i]   <= {{DistW{1'b0}}, r6_m[i]} * {{DistW{1'b0}}, r6_m[i]};
            end
            r5_vmag  <= w_geo.vmag;
            r5_dneg  <= w_geo.dneg;
            r5_vneg  <= w_geo.vneg;
            r6_sat   <= |w_big;
            r7_sat   <= r6_sat;
            r8_dist2 <= w_dist2;
            r8_oor   <= w_dist2 >= {2'b00, r_rad2};
        end
    end

    assign w_svld[0]  = r8_vld;
    assign w_srem[0]  = r8_dist2;
    assign w_sroot[0] = '0;
    assign w_soor[0]  = r8_oor;

    for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
        sat_sqrt_cell #(
            .STEP  (k),
            .PAY_W (1)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_svld[k]),
            .i_rem   (w_srem[k]),
            .i_root  (w_sroot[k]),
            .i_pay   (w_soor[k]),
            .o_vld   (w_svld[k+1]),
            .o_rem   (w_srem[k+1]),
            .o_root  (w_sroot[k+1]),
            .o_pay   (w_soor[k+1])
        );
    end

    // stage 9: (radius - distance) * gain
    assign w_dist  = w_sroot[SqrtSteps][DistW-1:0];
    assign w_diff  = {1'b0, r_att_rad} - {1'b0, w_dist};
    assign w_wprod = $signed({1'b0, w_diff}) * r_att_gain;

    // stage 10: magnitude for the divider
    assign w_pmag = r9_prod[63] ? -r9_prod : r9_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_vld  <= 1'b0;
            r10_vld <= 1'b0;
        end else if (w_en) begin
            r9_vld  <= w_svld[SqrtSteps];
            r10_vld <= r9_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_prod          <= w_wprod;
            r9_dist          <= w_dist;
            r9_oor           <= w_soor[SqrtSteps];
            r10_rem          <= w_pmag[WQW+DistW-1:WQW];
            r10_pay.num_lo   <= w_pmag[WQW-1:0];
            r10_pay.neg      <= r9_prod[63];
            r10_pay.distance <= r9_dist;
            r10_pay.oor      <= r9_oor;
        end
    end

    assign w_wvld[0] = r10_vld;
    assign w_wrem[0] = r10_rem;
    assign w_wden[0] = r_att_rad;
    assign w_wq[0]   = '0;
    assign w_wpay[0] = r10_pay;

    for (genvar k = 0; k < WQW; k++) begin : g_wdiv
        sat_div_cell #(
            .REM_W (DistW),
            .Q_W   (WQW),
            .PAY_W ($bits(t_wgt))
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_vld   (w_wvld[k]),
            .i_rem   (w_wrem[k]),
            .i_den   (w_wden[k]),
            .i_bit   (w_wpay[k].num_lo[WQW-1-k]),
            .i_q     (w_wq[k]),
            .i_pay   (w_wpay[k]),
            .o_vld   (w_wvld[k+1]),
            .o_rem   (w_wrem[k+1]),
            .o_den   (w_wden[k+1]),
            .o_q     (w_wq[k+1]),
            .o_pay   (w_wpay[k+1])
        );
    end

    assign w_last = w_wpay[WQW];
    assign w_q    = w_wq[WQW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_out_w   <= '0;
            r_out_d   <= '0;
            r_out_oor <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_wvld[WQW];
            r_out_w   <= w_last.oor ? '0 : (w_last.neg ? -w_q : w_q);
            r_out_d   <= w_last.oor ? '1 : w_last.distance;
            r_out_oor <= w_last.oor;
        end
    end

    assign o_out_valid        = r_out_vld;
    assign o_falloff_weight   = r_out_w;
    assign o_closest_distance = r_out_d;
    assign o_out_of_range     = r_out_oor;

    a_oor_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_of_range) |->
        (o_closest_distance == '1 && o_falloff_weight == '0))
        else $error("out-of-range beat with live fields");

    a_in_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_of_range) |-> (o_closest_distance < r_att_rad))
        else $error("in-range distance not below radius");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && i_out_stall) |=> (r_out_vld && $stable(r_out_w) && $stable(r_out_d)))
        else $error("stalled result changed");

    a_zero_rad: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r8_vld && r_rad2 == '0) |-> r8_oor)
        else $error("zero radius gave in-range item");

endmodule

### hw/rtl/sat_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_div_cell: one restoring division step
// Shifts one numerator bit into the partial remainder, subtracts the divisor
// when it fits and appends one quotient bit; registers everything onward.
// ----------------------------------------------------------------------------
module sat_div_cell #(
    parameter int REM_W = 31,
    parameter int Q_W   = 32,
    parameter int PAY_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [REM_W-1:0] i_rem,
    input  logic [REM_W-1:0] i_den,
    input  logic             i_bit,
    input  logic [Q_W-1:0]   i_q,
    input  logic [PAY_W-1:0] i_pay,
    output logic             o_vld,
    output logic [REM_W-1:0] o_rem,
    output logic [REM_W-1:0] o_den,
    output logic [Q_W-1:0]   o_q,
    output logic [PAY_W-1:0] o_pay
);

    logic [REM_W:0]   w_rem2;
    logic [REM_W:0]   w_diff;
    logic             w_ge;
    logic             r_vld;
    logic [REM_W-1:0] r_rem;
    logic [REM_W-1:0] r_den;
    logic [Q_W-1:0]   r_q;
    logic [PAY_W-1:0] r_pay;

    assign w_rem2 = {i_rem, i_bit};
    assign w_diff = w_rem2 - {1'b0, i_den};
    assign w_ge   = w_rem2 >= {1'b0, i_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= w_ge ? w_diff[REM_W-1:0] : w_rem2[REM_W-1:0];
            r_den <= i_den;
            r_q   <= {i_q[Q_W-2:0], w_ge};
            r_pay <= i_pay;
        end
    end

    assign o_vld = r_vld;
    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_q   = r_q;
    assign o_pay = r_pay;

endmodule

### hw/rtl/sat_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sat_sqrt_cell: one integer square root step
// Tries the next result bit against the remainder and registers the updated
// remainder and root for the following cell.
// ----------------------------------------------------------------------------
module sat_sqrt_cell
    import sat_pkg::*;
#(
    parameter int STEP  = 0,
    parameter int PAY_W = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  logic [RootW-1:0] i_rem,
    input  logic [RootW-1:0] i_root,
    input  logic [PAY_W-1:0] i_pay,
    output logic             o_vld,
    output logic [RootW-1:0] o_rem,
    output logic [RootW-1:0] o_root,
    output logic [PAY_W-1:0] o_pay
);

    localparam int Sh = RootW - 2 - 2 * STEP;
    localparam logic [RootW-1:0] Bit = {{(RootW-1){1'b0}}, 1'b1} << Sh;

    logic [RootW:0]   w_try;
    logic             w_ge;
    logic             r_vld;
    logic [RootW-1:0] r_rem;
    logic [RootW-1:0] r_root;
    logic [PAY_W-1:0] r_pay;

    assign w_try = {1'b0, i_root} + {1'b0, Bit};
    assign w_ge  = {1'b0, i_rem} >= w_try;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_en) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= w_ge ? (i_rem - w_try[RootW-1:0]) : i_rem;
            r_root <= w_ge ? ((i_root >> 1) + Bit) : (i_root >> 1);
            r_pay  <= i_pay;
        end
    end

    assign o_vld  = r_vld;
    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_pay  = r_pay;

endmodule

### tb/segment_attractor_falloff_weight_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// segment_attractor_falloff_weight_tb: self-checking bench
// Sends 3D segments and predicts each closest-point distance and falloff
// weight in the bench. Results are compared field by field in order. Runs a
// directed pass, then random passes under several attractor settings, with
// random valid gaps and output stalls.
// ----------------------------------------------------------------------------
module segment_attractor_falloff_weight_tb;
    import sat_pkg::*;

    typedef struct {
        logic signed [CoordW-1:0] sx, sy, sz, ex, ey, ez;
    } t_segment;

    typedef struct {
        logic signed [CoordW-1:0] weight;
        logic [DistW-1:0]         distance;
        logic                     oor;
    } t_falloff;

    localparam int  DrainCycles = 120;
    localparam logic [31:0] MaxPos = 32'h7FFF_FFFF;
    localparam logic [31:0] MinNeg = 32'h8000_0000;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0]       i_cfg_idx = CFG_ATT_X;
    logic [CoordW-1:0]        i_cfg_data = '0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_stall;
    logic signed [CoordW-1:0] i_start_x = '0, i_start_y = '0, i_start_z = '0;
    logic signed [CoordW-1:0] i_end_x = '0, i_end_y = '0, i_end_z = '0;
    logic                     o_out_valid;
    logic                     i_out_stall = 1'b0;
    logic signed [CoordW-1:0] o_falloff_weight;
    logic [DistW-1:0]         o_closest_distance;
    logic                     o_out_of_range;

    // attractor settings mirrored in the bench
    logic signed [CoordW-1:0] att_x = '0, att_y = '0, att_z = '0, att_gain = '0;
    logic [DistW-1:0]         att_radius = '0;

    t_falloff    pending_results[$];
    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    bit          failed = 1'b0;

    segment_attractor_falloff_weight dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint unsigned magnitude(input longint x);
        return (x < 0) ? -x : x;
    endfunction

    function automatic t_falloff predict_falloff(input t_segment sg);
        longint            s[3], d[3], v[3], a[3], e;
        logic [127:0]      len2, pos, neg, rem;
        longint unsigned   t, off, m, dist2, root, rm, bitv;
        bit                sat;
        longint            w, r;
        t_falloff          res;
        len2 = '0; pos = '0; neg = '0; t = 0; dist2 = 0; sat = 1'b0;
        a[0] = att_x; a[1] = att_y; a[2] = att_z;
        s[0] = sg.sx; s[1] = sg.sy; s[2] = sg.sz;
        d[0] = longint'(sg.ex) - s[0];
        d[1] = longint'(sg.ey) - s[1];
        d[2] = longint'(sg.ez) - s[2];
        for (int i = 0; i < 3; i++) begin
            v[i] = a[i] - s[i];
            len2 += 128'(magnitude(d[i])) * 128'(magnitude(d[i]));
            if ((d[i] < 0) == (v[i] < 0))
                pos += 128'(magnitude(d[i])) * 128'(magnitude(v[i]));
            else
                neg += 128'(magnitude(d[i])) * 128'(magnitude(v[i]));
        end
        // projection fraction, clamped to the segment
        if (len2 != 0 && neg < pos) begin
            rem = pos - neg;
            if (rem >= len2) begin
                t = 64'd1 << TBits;
            end else begin
                for (int i = 0; i < TBits; i++) begin
                    rem = rem << 1;
                    t = t << 1;
                    if (rem >= len2) begin
                        rem -= len2;
                        t |= 1;
                    end
                end
            end
        end
        for (int i = 0; i < 3; i++) begin
            off = (magnitude(d[i]) * t) >> TBits;
            e = -v[i] + ((d[i] < 0) ? -longint'(off) : longint'(off));
            m = magnitude(e);
            if (m >= (64'd1 << 31)) sat = 1'b1;
            else dist2 += m * m;
        end
        if (sat) dist2 = '1;
        if (dist2 >= 64'(att_radius) * 64'(att_radius)) begin
            res.weight = '0;
            res.distance = MaxPos[DistW-1:0];
            res.oor = 1'b1;
            return res;
        end
        rm = dist2; root = 0;
        for (bitv = 64'd1 << 62; bitv != 0; bitv >>= 2) begin
            if (rm >= root + bitv) begin
                rm -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
        end
        r = longint'(att_radius);
        w = (r - longint'(root)) * longint'(att_gain) / r;
        res.weight = w[31:0];
        res.distance = root[DistW-1:0];
        res.oor = 1'b0;
        return res;
    endfunction

    task automatic write_reg(input t_cfg_idx idx, input logic [CoordW-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_ATT_X:      att_x = data;
            CFG_ATT_Y:      att_y = data;
            CFG_ATT_Z:      att_z = data;
            CFG_ATT_RADIUS: att_radius = data[DistW-1:0];
            CFG_ATT_GAIN:   att_gain = data;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_attractor(input logic [31:0] x, y, z, rad, gain);
        write_reg(CFG_ATT_X, x);
        write_reg(CFG_ATT_Y, y);
        write_reg(CFG_ATT_Z, z);
        write_reg(CFG_ATT_RADIUS, rad);
        write_reg(CFG_ATT_GAIN, gain);
    endtask

    // valid stays high from one beat to the next unless a gap is drawn
    task automatic send_segment(input t_segment sg);
        if ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < gap_pct) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_start_x <= sg.sx; i_start_y <= sg.sy; i_start_z <= sg.sz;
        i_end_x <= sg.ex; i_end_y <= sg.ey; i_end_z <= sg.ez;
        do @(posedge i_clk); while (o_in_stall);
        pending_results.push_back(predict_falloff(sg));
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
    endtask

    function automatic t_segment seg(input logic [31:0] sx, sy, sz, ex, ey, ez);
        t_segment sg;
        sg.sx = sx; sg.sy = sy; sg.sz = sz; sg.ex = ex; sg.ey = ey; sg.ez = ez;
        return sg;
    endfunction

    // coordinate near the attractor axis value, within span
    function automatic logic [31:0] near_coord(input logic signed [31:0] c,
                                               input int unsigned span);
        longint o;
        o = longint'($urandom_range(2 * span)) - longint'(span);
        return 32'(longint'(c) + o);
    endfunction

    task automatic test_directed;
        set_attractor(32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0010_0000, 32'h0001_0000);
        send_segment(seg(0, 0, 0, 0, 0, 0));                       // zero length
        send_segment(seg(32'h1_0000, 32'hFFFF_0000, 0,
                         32'h1_0000, 32'hFFFF_0000, 0));           // on attractor
        send_segment(seg(32'hFFF0_0000, 32'hFFFF_0000, 32'h8000,
                         32'h0010_0000, 32'hFFFF_0000, 32'h8000)); // interior projection
        send_segment(seg(32'h0004_0000, 0, 0, 32'h0008_0000, 0, 0)); // clamp to start
        send_segment(seg(32'hFFF8_0000, 0, 0, 32'hFFFC_0000, 0, 0)); // clamp to end
        send_segment(seg(MaxPos, MaxPos, MaxPos, MinNeg, MinNeg, MinNeg));
        send_segment(seg(MinNeg, MinNeg, MinNeg, MinNeg, MinNeg, MinNeg)); // saturate
        send_segment(seg(MaxPos, MaxPos, MaxPos, MaxPos, MaxPos, MaxPos));
        send_segment(seg(32'h0010_0000, 32'hFFFF_0000, 0,
                         32'h0010_0000, 32'hFFFF_0000, 0));        // inside radius
        send_segment(seg(32'h000F_FFFF, 32'hFFFF_0000, 0,
                         32'h0020_0000, 32'hFFFF_0000, 0));        // just inside
        drain();
        // widest radius, most negative gain, attractor at the corners
        set_attractor(MinNeg, MaxPos, MinNeg, MaxPos, MinNeg);
        send_segment(seg(MinNeg, MaxPos, MinNeg, MaxPos, MinNeg, MaxPos));
        send_segment(seg(MinNeg, MaxPos, MinNeg, MinNeg, MaxPos, MinNeg));
        send_segment(seg(0, 0, 0, MinNeg, MaxPos, MinNeg));
        send_segment(seg(0, 0, 0, 0, 0, 0));
        send_segment(seg(32'hC000_0000, 32'h4000_0000, 32'hC000_0000, 0, 0, 0));
        drain();
        // zero radius: everything out of range
        set_attractor(0, 0, 0, 0, MaxPos);
        send_segment(seg(0, 0, 0, 0, 0, 0));
        send_segment(seg(32'h1, 0, 0, 32'hFFFF_FFFF, 0, 0));
        drain();
        set_attractor(MaxPos, MaxPos, MaxPos, 32'h1, MaxPos);     // tiny radius
        send_segment(seg(MaxPos, MaxPos, MaxPos, MaxPos, MaxPos, MaxPos));
        send_segment(seg(MaxPos, MaxPos, 32'h7FFF_FFFE, MaxPos, MaxPos, MaxPos));
        drain();
    endtask

    task automatic test_random(input int unsigned n, input int unsigned gaps,
                               input int unsigned stalls, input logic [31:0] rad,
                               input logic [31:0] gain);
        t_segment    sg;
        int unsigned span, kind;
        gap_pct = gaps;
        stall_pct = stalls;
        set_attractor($urandom_range(32'h0100_0000) - 32'h0080_0000,
                      $urandom, $urandom_range(32'h00FF_FFFF), rad, gain);
        span = (rad[30:0] > 31'h0800_0000) ? 32'h0800_0000 : rad[30:0] + 1;
        for (int unsigned k = 0; k < n; k++) begin
            kind = $urandom_range(9);
            if (kind < 6) begin
                sg = seg(near_coord(att_x, span), near_coord(att_y, span),
                         near_coord(att_z, span), near_coord(att_x, 2 * span),
                         near_coord(att_y, 2 * span), near_coord(att_z, 2 * span));
            end else if (kind < 8) begin
                sg = seg($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            end else begin
                sg = seg(near_coord(att_x, span), near_coord(att_y, span),
                         near_coord(att_z, span), 0, 0, 0);
                sg.ex = sg.sx; sg.ey = sg.sy; sg.ez = sg.sz;
            end
            send_segment(sg);
        end
        drain();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) i_out_stall <= 1'b0;
        else i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        t_falloff exp_r;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result beat");
                failed = 1'b1;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_falloff_weight !== exp_r.weight) begin
                    $error("falloff_weight: expected %0d, got %0d",
                           exp_r.weight, o_falloff_weight);
                    failed = 1'b1;
                end
                if (o_closest_distance !== exp_r.distance) begin
                    $error("closest_distance: expected %0d, got %0d",
                           exp_r.distance, o_closest_distance);
                    failed = 1'b1;
                end
                if (o_out_of_range !== exp_r.oor) begin
                    $error("out_of_range: expected %0d, got %0d",
                           exp_r.oor, o_out_of_range);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        #20ms;
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(170, 19, 72, 32'h0200_0000, $urandom);
        test_random(170, 72, 19, MaxPos, MinNeg);
        test_random(170, 0, 0, $urandom_range(32'h0001_0000, 32'h0400_0000), MaxPos);
        if (pending_results.size() != 0) failed = 1'b1;
        if (!failed)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
